// ===== design/frustum_box_cull_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the frustum box cull block
// Short forms for the concurrent checks used in the design files.
// ---------------------------------------------------------------------------
`ifndef FRUSTUM_BOX_CULL_MACROS_SVH
`define FRUSTUM_BOX_CULL_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define FBC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define FBC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define FBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fbc_pkg.sv =====
// ---------------------------------------------------------------------------
// Frustum box cull package
// Shared widths, counts and the pipeline tag type.
// ---------------------------------------------------------------------------
package fbc_pkg;

  // Default number of fraction bits in the fixed-point format.
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Width of a matrix element, a box corner and a projection term.
  localparam int unsigned DATA_W = 32;

  // Width of one plane coefficient.
  localparam int unsigned COEF_W = 48;

  // Six planes, each with a, b, c and d; three spatial axes.
  localparam int unsigned NUM_PLANES = 6;
  localparam int unsigned NUM_COEFS  = 4;
  localparam int unsigned NUM_AXES   = 3;

  // Control tag that travels with a plane through the dot-product pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } fbc_tag_t;

endpackage

// ===== design/fbc_dot.sv =====
// ---------------------------------------------------------------------------
// Frustum box cull plane distance pipeline
// Takes one plane per cycle, forms the exact positive-vertex distance and
// reports the combined visibility after the last plane of a box.
// ---------------------------------------------------------------------------
module fbc_dot
  import fbc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fbc_tag_t                           tag_i,
  input  logic [NUM_COEFS*COEF_W-1:0]        plane_i,
  input  logic [NUM_AXES-1:0][DATA_W-1:0]    box_lo_i,
  input  logic [NUM_AXES-1:0][DATA_W-1:0]    box_hi_i,
  output logic                               result_valid_o,
  output logic                               visible_o
);

  // Coefficients are split into a signed upper part and an unsigned lower word.
  localparam int unsigned HI_W   = COEF_W - DATA_W;
  localparam int unsigned PH_W   = HI_W + DATA_W;
  localparam int unsigned PLO_W  = 2 * DATA_W + 1;
  localparam int unsigned PROD_W = COEF_W + DATA_W;
  localparam int unsigned D_W    = COEF_W + FRAC_BITS;
  localparam int unsigned SUM_W  = ((PROD_W > D_W) ? PROD_W : D_W) + 2;

  logic signed [HI_W-1:0]   coef_hi [NUM_AXES];
  logic        [DATA_W-1:0] coef_lo [NUM_AXES];
  logic signed [DATA_W-1:0] vert    [NUM_AXES];

  logic signed [PH_W-1:0]   s1_ph_q   [NUM_AXES];
  logic signed [PLO_W-1:0]  s1_pl_q   [NUM_AXES];
  logic signed [COEF_W-1:0] s1_d_q;
  logic signed [PROD_W-1:0] s2_prod_q [NUM_AXES];
  logic signed [D_W-1:0]    s2_d_q;
  logic signed [SUM_W-1:0]  s3_a_q;
  logic signed [SUM_W-1:0]  s3_b_q;
  logic signed [SUM_W-1:0]  plane_dist;

  fbc_tag_t s1_tag_q, s2_tag_q, s3_tag_q;
  logic     cull_q;
  logic     cull_next;
  logic     result_valid_q;
  logic     visible_q;

  // Positive vertex: the max corner where the normal component is not negative.
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      coef_hi[i] = $signed(plane_i[i*COEF_W+DATA_W +: HI_W]);
      coef_lo[i] = plane_i[i*COEF_W +: DATA_W];
      vert[i]    = plane_i[i*COEF_W+COEF_W-1] ? $signed(box_lo_i[i])
                                              : $signed(box_hi_i[i]);
    end
  end

  // Datapath stages: partial products, per-axis products, two adds.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      s1_ph_q[i]   <= coef_hi[i] * vert[i];
      s1_pl_q[i]   <= $signed({1'b0, coef_lo[i]}) * vert[i];
      s2_prod_q[i] <= (PROD_W'(s1_ph_q[i]) <<< DATA_W) + PROD_W'(s1_pl_q[i]);
    end
    s1_d_q <= $signed(plane_i[NUM_AXES*COEF_W +: COEF_W]);
    s2_d_q <= D_W'(s1_d_q) <<< FRAC_BITS;
    s3_a_q <= SUM_W'(s2_prod_q[0]) + SUM_W'(s2_prod_q[1]);
    s3_b_q <= SUM_W'(s2_prod_q[2]) + SUM_W'(s2_d_q);
    if (s3_tag_q.valid && s3_tag_q.last) begin
      visible_q <= !cull_next;
    end
  end

  // A box is culled as soon as one plane gives a negative distance.
  assign plane_dist = s3_a_q + s3_b_q;
  assign cull_next  = (s3_tag_q.first ? 1'b0 : cull_q) | plane_dist[SUM_W-1];

  // Tag pipeline, cull flag and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q       <= '0;
      s2_tag_q       <= '0;
      s3_tag_q       <= '0;
      cull_q         <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      s1_tag_q       <= tag_i;
      s2_tag_q       <= s1_tag_q;
      s3_tag_q       <= s2_tag_q;
      result_valid_q <= s3_tag_q.valid && s3_tag_q.last;
      if (s3_tag_q.valid) begin
        cull_q <= cull_next;
      end
    end
  end

  assign result_valid_o = result_valid_q;
  assign visible_o      = visible_q;

endmodule

// ===== design/frustum_box_cull.sv =====
// ---------------------------------------------------------------------------
// Frustum box cull top level
// Camera matrix store, frustum plane builder and box visibility test.
// ---------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low. Loading element
// 15 rebuilds the six planes through one shared 32x32 multiplier and the
// single write port of the plane memory, holding busy_o high and
// cfg_ready_o low. A box test reads one plane per cycle, so busy_o is high
// until its last plane is read; a new box can be taken while the last one
// is in the distance pipeline. Results appear on visible_o with
// result_valid_o high for one cycle, after the plane read and the fbc_dot
// pipeline. The receiver cannot stall: result_valid_o is a strobe. After
// reset all planes read as zero and every box is visible.
// ---------------------------------------------------------------------------
`include "frustum_box_cull_macros.svh"

module frustum_box_cull
  import fbc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Item command interface
  input  logic              start_i,
  output logic              busy_o,
  input  logic              kind_i,
  input  logic [3:0]        element_index_i,
  input  logic [DATA_W-1:0] element_value_i,
  input  logic [DATA_W-1:0] min_x_i,
  input  logic [DATA_W-1:0] min_y_i,
  input  logic [DATA_W-1:0] min_z_i,
  input  logic [DATA_W-1:0] max_x_i,
  input  logic [DATA_W-1:0] max_y_i,
  input  logic [DATA_W-1:0] max_z_i,
  // Result strobe
  output logic              result_valid_o,
  output logic              visible_o,
  // Configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CAM_DEPTH = 16;
  localparam int unsigned PLANE_AW  = $clog2(NUM_PLANES);
  localparam int unsigned ROW_W     = NUM_COEFS * COEF_W;
  localparam int unsigned SP_W      = 2 * DATA_W - FRAC_BITS;
  localparam int unsigned M_W       = SP_W + 1;
  localparam int unsigned PC_W      = M_W + 1;
  localparam int unsigned SAT_W     = (PC_W > COEF_W) ? PC_W : COEF_W + 1;

  localparam logic [PLANE_AW-1:0] LAST_PLANE = PLANE_AW'(NUM_PLANES - 1);
  localparam logic [3:0]          LAST_ELEM  = 4'd15;
  localparam logic [1:0]          LAST_ROW   = 2'd3;
  localparam logic [1:0]          COL_DEPTH  = 2'd2;
  localparam logic [1:0]          COL_OFFSET = 2'd3;
  localparam logic                KIND_LOAD  = 1'b0;
  localparam logic                KIND_BOX   = 1'b1;

  localparam logic signed [SAT_W-1:0] COEF_MAX = (SAT_W'(1) <<< (COEF_W - 1)) - 1;
  localparam logic signed [SAT_W-1:0] COEF_MIN = ~COEF_MAX;

  localparam logic signed [DATA_W-1:0] PROJ_X_RST  = 32'sd65536;
  localparam logic signed [DATA_W-1:0] PROJ_Y_RST  = 32'sd116508;
  localparam logic signed [DATA_W-1:0] DEPTH_S_RST = 32'sd65865;
  localparam logic signed [DATA_W-1:0] DEPTH_O_RST = -32'sd32932;

  typedef enum logic [1:0] {
    CFG_PROJ_X_SCALE  = 2'd0,
    CFG_PROJ_Y_SCALE  = 2'd1,
    CFG_DEPTH_SCALE   = 2'd2,
    CFG_DEPTH_OFFSET  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BOX,
    S_RD,
    S_MUL,
    S_ACC,
    S_WR
  } state_e;

  state_e state_q;

  logic [PLANE_AW-1:0] plane_q;
  logic [1:0]          row_q;
  logic [1:0]          col_q;
  logic                planes_valid_q;
  logic                accept;
  logic                rebuilding;

  logic signed [DATA_W-1:0] proj_x_q, proj_y_q, depth_s_q, depth_o_q;

  logic [DATA_W-1:0]    cam_mem [CAM_DEPTH];
  logic [CAM_DEPTH-1:0] cam_valid_q;
  logic [DATA_W-1:0]    cam_rdata_q;
  logic                 cam_rvalid_q;
  logic                 cam_we;
  logic [3:0]           cam_raddr;
  logic signed [DATA_W-1:0] cam_op;
  logic signed [DATA_W-1:0] term;

  logic signed [2*DATA_W-1:0] prod_q;
  logic signed [SP_W-1:0]     sp;
  logic signed [M_W-1:0]      m_q [NUM_AXES];
  logic signed [DATA_W-1:0]   m3_q;
  logic signed [PC_W-1:0]     pc;
  logic signed [SAT_W-1:0]    pc_ext;
  logic [COEF_W-1:0]          coef_sat;

  logic [ROW_W-1:0] plane_mem [NUM_PLANES];
  logic [ROW_W-1:0] plane_rdata_q;
  logic [ROW_W-1:0] plane_word;
  logic             plane_we;
  fbc_tag_t         rd_tag_q;

  logic [NUM_AXES-1:0][DATA_W-1:0] box_lo_q, box_hi_q;

  // Handshake decode.
  assign busy_o      = (state_q != S_IDLE);
  assign accept      = start_i && !busy_o;
  assign rebuilding  = (state_q == S_RD) || (state_q == S_MUL) ||
                       (state_q == S_ACC) || (state_q == S_WR);
  assign cfg_ready_o = !rebuilding;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proj_x_q  <= PROJ_X_RST;
      proj_y_q  <= PROJ_Y_RST;
      depth_s_q <= DEPTH_S_RST;
      depth_o_q <= DEPTH_O_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PROJ_X_SCALE: proj_x_q  <= $signed(cfg_data_i);
        CFG_PROJ_Y_SCALE: proj_y_q  <= $signed(cfg_data_i);
        CFG_DEPTH_SCALE:  depth_s_q <= $signed(cfg_data_i);
        CFG_DEPTH_OFFSET: depth_o_q <= $signed(cfg_data_i);
      endcase
    end
  end

  // Sequencer for box reads and the plane rebuild.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      plane_q        <= '0;
      row_q          <= '0;
      col_q          <= '0;
      planes_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (kind_i == KIND_BOX) begin
              state_q <= S_BOX;
              plane_q <= '0;
            end else if (element_index_i == LAST_ELEM) begin
              state_q <= S_RD;
              row_q   <= '0;
              col_q   <= '0;
            end
          end
        end
        S_BOX: begin
          if (plane_q == LAST_PLANE) begin
            state_q <= S_IDLE;
          end else begin
            plane_q <= plane_q + 1'b1;
          end
        end
        S_RD:  state_q <= S_MUL;
        S_MUL: state_q <= S_ACC;
        S_ACC: begin
          if (col_q == COL_OFFSET) begin
            state_q <= S_WR;
            plane_q <= '0;
          end else begin
            col_q   <= col_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_WR: begin
          if (plane_q == LAST_PLANE) begin
            if (row_q == LAST_ROW) begin
              state_q        <= S_IDLE;
              planes_valid_q <= 1'b1;
            end else begin
              row_q   <= row_q + 1'b1;
              col_q   <= '0;
              state_q <= S_RD;
            end
          end else begin
            plane_q <= plane_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Camera element memory with per-entry valid bits for the zero reset.
  assign cam_we    = accept && (kind_i == KIND_LOAD);
  assign cam_raddr = {row_q, col_q};

  always_ff @(posedge clk_i) begin
    if (cam_we) begin
      cam_mem[element_index_i] <= element_value_i;
    end
    cam_rdata_q <= cam_mem[cam_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_valid_q  <= '0;
      cam_rvalid_q <= 1'b0;
    end else begin
      if (cam_we) begin
        cam_valid_q[element_index_i] <= 1'b1;
      end
      cam_rvalid_q <= cam_valid_q[cam_raddr];
    end
  end

  assign cam_op = cam_rvalid_q ? $signed(cam_rdata_q) : '0;

  // Projection term for the current column of the camera row.
  always_comb begin
    unique case (col_q)
      2'd0:       term = proj_x_q;
      2'd1:       term = proj_y_q;
      COL_DEPTH:  term = depth_s_q;
      COL_OFFSET: term = depth_o_q;
    endcase
  end

  // Scaled product, floor shift, and row accumulation of the combined matrix.
  assign sp = SP_W'(prod_q >>> FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      prod_q <= cam_op * term;
      if (col_q == COL_DEPTH) begin
        m3_q <= cam_op;
      end
    end
    if (state_q == S_ACC) begin
      unique case (col_q)
        2'd0:       m_q[0] <= M_W'(sp);
        2'd1:       m_q[1] <= M_W'(sp);
        COL_DEPTH:  m_q[2] <= M_W'(sp);
        COL_OFFSET: m_q[2] <= m_q[2] + M_W'(sp);
      endcase
    end
  end

  // Plane coefficient from column 3 plus or minus the plane's column, saturated.
  always_comb begin
    pc = plane_q[0] ? (PC_W'(m3_q) - PC_W'(m_q[plane_q[PLANE_AW-1:1]]))
                    : (PC_W'(m3_q) + PC_W'(m_q[plane_q[PLANE_AW-1:1]]));
    pc_ext = SAT_W'(pc);
    priority if (pc_ext > COEF_MAX) begin
      coef_sat = COEF_MAX[COEF_W-1:0];
    end else if (pc_ext < COEF_MIN) begin
      coef_sat = COEF_MIN[COEF_W-1:0];
    end else begin
      coef_sat = pc_ext[COEF_W-1:0];
    end
  end

  // Plane memory: one row per plane, one coefficient lane written at a time.
  assign plane_we = (state_q == S_WR);

  always_ff @(posedge clk_i) begin
    if (plane_we) begin
      plane_mem[plane_q][row_q*COEF_W +: COEF_W] <= coef_sat;
    end
    plane_rdata_q <= plane_mem[plane_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_tag_q <= '0;
    end else begin
      rd_tag_q.valid <= (state_q == S_BOX);
      rd_tag_q.first <= (plane_q == '0);
      rd_tag_q.last  <= (plane_q == LAST_PLANE);
    end
  end

  // Until the first rebuild every plane reads as zero.
  assign plane_word = planes_valid_q ? plane_rdata_q : '0;

  // Box corners held for the duration of the plane reads.
  always_ff @(posedge clk_i) begin
    if (accept && (kind_i == KIND_BOX)) begin
      box_lo_q <= {min_z_i, min_y_i, min_x_i};
      box_hi_q <= {max_z_i, max_y_i, max_x_i};
    end
  end

  fbc_dot #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dot (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tag_i          (rd_tag_q),
    .plane_i        (plane_word),
    .box_lo_i       (box_lo_q),
    .box_hi_i       (box_hi_q),
    .result_valid_o (result_valid_o),
    .visible_o      (visible_o)
  );

  // A box transaction holds the block busy while its planes are read.
  `FBC_ASSERT_NEXT(a_box_busy, accept && (kind_i == KIND_BOX), busy_o, "box not issued")
  // Boxes are spaced apart by their plane reads, so strobes never touch.
  `FBC_ASSERT_NEXT(a_strobe_single, result_valid_o, !result_valid_o, "double strobe")
  // Configuration is held off only by a rebuild.
  `FBC_ASSERT_IMP(a_cfg_hold, !cfg_ready_o, busy_o, "cfg stalled while idle")
  // The last plane read releases the block.
  `FBC_ASSERT_NEXT(a_issue_end, (state_q == S_BOX) && (plane_q == LAST_PLANE), !busy_o,
                   "box issue overran")

endmodule

// ===== tb/frustum_box_cull_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Frustum box cull testbench
// Drives camera matrix loads and box tests through the command interface,
// reprograms the projection terms between phases, and checks each visibility
// strobe against a plane builder and positive-vertex test kept in the bench.
// ---------------------------------------------------------------------------
module tb;
  import fbc_pkg::*;

  localparam int unsigned FRAC            = FRAC_BITS_DEF;
  localparam int unsigned NUM_ELEMENTS    = 16;
  localparam int unsigned LAST_ELEMENT    = 15;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam int unsigned DRAIN_CYCLES    = 80;
  localparam int unsigned ITEMS_PER_PHASE = 210;
  localparam int unsigned NUM_PHASES      = 6;

  // Projection terms after reset.
  localparam logic [DATA_W-1:0] RST_PROJ_X       = 32'd65536;
  localparam logic [DATA_W-1:0] RST_PROJ_Y       = 32'd116508;
  localparam logic [DATA_W-1:0] RST_DEPTH_SCALE  = 32'd65865;
  localparam logic [DATA_W-1:0] RST_DEPTH_OFFSET = 32'hFFFF_7F5C;

  localparam logic [DATA_W-1:0] MOST_NEGATIVE = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MOST_POSITIVE = 32'h7FFF_FFFF;

  typedef enum logic {KIND_LOAD = 1'b0, KIND_BOX = 1'b1} item_kind_e;

  typedef enum logic [1:0] {
    REG_PROJ_X       = 2'd0,
    REG_PROJ_Y       = 2'd1,
    REG_DEPTH_SCALE  = 2'd2,
    REG_DEPTH_OFFSET = 2'd3
  } cull_reg_e;

  // One box corner; index 0 is x, 1 is y, 2 is z.
  typedef logic [NUM_AXES-1:0][DATA_W-1:0] corner_t;

  // Tracks the camera matrix, the frustum planes and the visibility verdicts
  // still owed by the block.
  class cull_scoreboard;
    logic [DATA_W-1:0]        proj_terms [4];
    logic [DATA_W-1:0]        camera [NUM_ELEMENTS];
    logic signed [COEF_W-1:0] planes [NUM_PLANES*NUM_COEFS];
    bit                       visible_expected [$];
    int                       mismatches;
    int                       boxes_seen;
    int                       culled_seen;
    int                       rebuilds;
    int                       reg_writes;

    function new();
      proj_terms[REG_PROJ_X]       = RST_PROJ_X;
      proj_terms[REG_PROJ_Y]       = RST_PROJ_Y;
      proj_terms[REG_DEPTH_SCALE]  = RST_DEPTH_SCALE;
      proj_terms[REG_DEPTH_OFFSET] = RST_DEPTH_OFFSET;
      foreach (camera[i]) camera[i] = '0;
      foreach (planes[i]) planes[i] = '0;
    endfunction

    function void note_failure(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, msg);
    endfunction

    function void write_reg(cull_reg_e idx, logic [DATA_W-1:0] value);
      proj_terms[idx] = value;
      reg_writes++;
    endfunction

    // Exact product of two fixed-point words, floored back to the fixed point.
    function longint scaled(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      longint prod;
      prod = longint'($signed(a)) * longint'($signed(b));
      return prod >>> FRAC;
    endfunction

    function logic signed [COEF_W-1:0] clamp_coef(longint v);
      longint lim;
      lim = longint'(1) <<< (COEF_W - 1);
      if (v > lim - 1) return COEF_W'(lim - 1);
      if (v < -lim) return COEF_W'(-lim);
      return COEF_W'(v);
    endfunction

    // Camera times projection, then column 3 plus or minus columns 0..2.
    function void build_planes();
      longint m [4][4];
      longint v;
      int     col;
      for (int r = 0; r < 4; r++) begin
        m[r][0] = scaled(camera[r*4 + 0], proj_terms[REG_PROJ_X]);
        m[r][1] = scaled(camera[r*4 + 1], proj_terms[REG_PROJ_Y]);
        m[r][2] = scaled(camera[r*4 + 2], proj_terms[REG_DEPTH_SCALE])
                + scaled(camera[r*4 + 3], proj_terms[REG_DEPTH_OFFSET]);
        m[r][3] = longint'($signed(camera[r*4 + 2]));
      end
      for (int p = 0; p < NUM_PLANES; p++) begin
        col = p >> 1;
        for (int k = 0; k < NUM_COEFS; k++) begin
          v = (p & 1) ? m[k][3] - m[k][col] : m[k][3] + m[k][col];
          planes[p*NUM_COEFS + k] = clamp_coef(v);
        end
      end
      rebuilds++;
    endfunction

    // Positive-vertex test, exact; any negative distance culls the box.
    function bit box_visible(corner_t lo, corner_t hi);
      logic signed [127:0] acc;
      logic signed [127:0] coef;
      logic signed [127:0] corner;
      bit                  vis;
      vis = 1'b1;
      for (int p = 0; p < NUM_PLANES; p++) begin
        coef = 128'(planes[p*NUM_COEFS + 3]);
        acc  = coef <<< FRAC;
        for (int i = 0; i < NUM_AXES; i++) begin
          coef = 128'(planes[p*NUM_COEFS + i]);
          if (coef >= 0) corner = 128'($signed(hi[i]));
          else corner = 128'($signed(lo[i]));
          acc = acc + coef * corner;
        end
        if (acc[127]) vis = 1'b0;
      end
      return vis;
    endfunction

    function void accept_item(item_kind_e kind, logic [3:0] idx,
                              logic [DATA_W-1:0] value, corner_t lo, corner_t hi);
      if (kind == KIND_LOAD) begin
        camera[idx] = value;
        if (idx == LAST_ELEMENT) build_planes();
      end else begin
        visible_expected.push_back(box_visible(lo, hi));
      end
    endfunction

    function void check_visibility(logic vis);
      bit want;
      if (visible_expected.size() == 0) begin
        note_failure($sformatf("visibility strobe %b with no box outstanding", vis));
        return;
      end
      want = visible_expected.pop_front();
      boxes_seen++;
      if (vis === 1'b0) culled_seen++;
      if (vis !== want)
        note_failure($sformatf("box %0d: visible expected %b, got %b",
                               boxes_seen, want, vis));
    endfunction

    function int pending();
      return visible_expected.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic              kind_i;
  logic [3:0]        element_index_i;
  logic [DATA_W-1:0] element_value_i;
  logic [DATA_W-1:0] min_x_i;
  logic [DATA_W-1:0] min_y_i;
  logic [DATA_W-1:0] min_z_i;
  logic [DATA_W-1:0] max_x_i;
  logic [DATA_W-1:0] max_y_i;
  logic [DATA_W-1:0] max_z_i;
  logic              result_valid_o;
  logic              visible_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i;
  logic [DATA_W-1:0] cfg_data_i;

  cull_scoreboard sb;
  int             burst_left;
  int             idle_cycles;

  frustum_box_cull dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .kind_i          (kind_i),
    .element_index_i (element_index_i),
    .element_value_i (element_value_i),
    .min_x_i         (min_x_i),
    .min_y_i         (min_y_i),
    .min_z_i         (min_z_i),
    .max_x_i         (max_x_i),
    .max_y_i         (max_y_i),
    .max_z_i         (max_z_i),
    .result_valid_o  (result_valid_o),
    .visible_o       (visible_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Free-running clock, 2 ns period.
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Observe every transaction at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_visibility(visible_o);
      if (start_i && !busy_o)
        sb.accept_item(item_kind_e'(kind_i), element_index_i, element_value_i,
                       {min_z_i, min_y_i, min_x_i}, {max_z_i, max_y_i, max_x_i});
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cull_reg_e'(cfg_index_i), cfg_data_i);
    end
  end

  // Watchdog: too long without any transaction means the block hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic logic [DATA_W-1:0] fixed(int whole);
    return whole <<< FRAC;
  endfunction

  function automatic logic [DATA_W-1:0] rand_extreme();
    case ($urandom_range(0, 3))
      0:       return MOST_NEGATIVE;
      1:       return MOST_POSITIVE;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Style 0: small values within plus or minus four; 1: extremes or raw words; 2: any of these.
  function automatic logic [DATA_W-1:0] rand_element(int style);
    int pick;
    pick = (style == 2) ? $urandom_range(0, 2) : style;
    if (pick == 0) return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
    if ($urandom_range(0, 1) == 0) return rand_extreme();
    return $urandom;
  endfunction

  // Mostly well-formed boxes around the origin, some inverted or wild ones.
  function automatic void rand_box(output corner_t lo, output corner_t hi);
    int                r;
    logic [DATA_W-1:0] c;
    logic [DATA_W-1:0] h;
    r = $urandom_range(0, 99);
    for (int i = 0; i < NUM_AXES; i++) begin
      c = $urandom_range(0, 32'h40_0000) - 32'h20_0000;
      h = $urandom_range(0, 32'h8_0000);
      if (r < 70) begin
        lo[i] = c - h;
        hi[i] = c + h;
      end else if (r < 80) begin
        lo[i] = c + h;
        hi[i] = c - h;
      end else if (r < 90) begin
        lo[i] = $urandom;
        hi[i] = $urandom;
      end else begin
        lo[i] = rand_extreme();
        hi[i] = rand_extreme();
      end
    end
  endfunction

  // Present one item; returns at the falling edge after its transaction,
  // with start_i still high so a following item needs no gap.
  task automatic send_item(item_kind_e kind, logic [3:0] idx, logic [DATA_W-1:0] value,
                           corner_t lo, corner_t hi);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    kind_i          <= kind;
    element_index_i <= idx;
    element_value_i <= value;
    {min_z_i, min_y_i, min_x_i} <= lo;
    {max_z_i, max_y_i, max_x_i} <= hi;
    start_i         <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  task automatic send_load(logic [3:0] idx, logic [DATA_W-1:0] value);
    send_item(KIND_LOAD, idx, value, {$urandom, $urandom, $urandom},
              {$urandom, $urandom, $urandom});
  endtask

  task automatic send_box(corner_t lo, corner_t hi);
    send_item(KIND_BOX, 4'($urandom_range(0, 15)), $urandom, lo, hi);
  endtask

  // Full matrix in index order, so the last load rebuilds the planes.
  task automatic load_matrix(int style);
    for (int e = 0; e < NUM_ELEMENTS; e++) send_load(4'(e), rand_element(style));
  endtask

  // Stop issuing and let every owed verdict and any rebuild finish.
  task automatic wait_idle();
    start_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_term(cull_reg_e idx, logic [DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic program_terms(logic [DATA_W-1:0] px, logic [DATA_W-1:0] py,
                               logic [DATA_W-1:0] ds, logic [DATA_W-1:0] dofs);
    write_term(REG_PROJ_X, px);
    write_term(REG_PROJ_Y, py);
    write_term(REG_DEPTH_SCALE, ds);
    write_term(REG_DEPTH_OFFSET, dofs);
    cfg_valid_i <= 1'b0;
  endtask

  // Random mix: whole matrices, stray element writes and many boxes.
  task automatic run_phase(int count);
    int      done;
    int      r;
    corner_t lo;
    corner_t hi;
    load_matrix($urandom_range(0, 2));
    done = NUM_ELEMENTS;
    while (done < count) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        load_matrix(($urandom_range(0, 99) < 60) ? 0 : $urandom_range(1, 2));
        done += NUM_ELEMENTS;
      end else if (r < 16) begin
        send_load(4'($urandom_range(0, 15)), rand_element(2));
        done++;
      end else begin
        rand_box(lo, hi);
        send_box(lo, hi);
        done++;
      end
    end
  endtask

  initial begin
    sb              = new();
    burst_left      = 0;
    idle_cycles     = 0;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    kind_i          = KIND_LOAD;
    element_index_i = '0;
    element_value_i = '0;
    min_x_i         = '0;
    min_y_i         = '0;
    min_z_i         = '0;
    max_x_i         = '0;
    max_y_i         = '0;
    max_z_i         = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = REG_PROJ_X;
    cfg_data_i      = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Before any rebuild the planes are zero, so even these boxes are visible.
    send_box({3{MOST_NEGATIVE}}, {3{MOST_POSITIVE}});
    send_box({3{MOST_POSITIVE}}, {3{MOST_NEGATIVE}});

    // Extreme element words, then an identity camera that replaces them.
    send_load(5, MOST_NEGATIVE);
    send_load(10, MOST_POSITIVE);
    for (int e = 0; e < NUM_ELEMENTS; e++) send_load(4'(e), (e % 5 == 0) ? fixed(1) : '0);

    // In front, behind, past the far plane, a point, and the full range both ways.
    send_box({fixed(4), fixed(-1), fixed(-1)}, {fixed(6), fixed(1), fixed(1)});
    send_box({fixed(-6), fixed(-1), fixed(-1)}, {fixed(-4), fixed(1), fixed(1)});
    send_box({fixed(1000), fixed(-1), fixed(-1)}, {fixed(1010), fixed(1), fixed(1)});
    send_box('0, '0);
    send_box({3{MOST_NEGATIVE}}, {3{MOST_POSITIVE}});
    send_box({3{MOST_POSITIVE}}, {3{MOST_NEGATIVE}});

    // Each phase reprograms the projection, then rebuilds and tests at random.
    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        1: program_terms(MOST_NEGATIVE, MOST_NEGATIVE, MOST_NEGATIVE, MOST_NEGATIVE);
        2: program_terms(MOST_POSITIVE, MOST_POSITIVE, MOST_POSITIVE, MOST_POSITIVE);
        3: program_terms(rand_element(0), rand_element(0), rand_element(0), rand_element(0));
        4: program_terms('0, '0, '0, '0);
        5: program_terms($urandom, $urandom, $urandom, $urandom);
        default: program_terms(RST_PROJ_X, RST_PROJ_Y, RST_DEPTH_SCALE, RST_DEPTH_OFFSET);
      endcase
      run_phase(ITEMS_PER_PHASE);
    end
    wait_idle();

    $display("Tested %0d boxes (%0d culled) over %0d plane rebuilds and %0d projection writes.",
             sb.boxes_seen, sb.culled_seen, sb.rebuilds, sb.reg_writes);
    $display("Mismatches: %0d, verdicts still owed: %0d.", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/fbc_pkg.sv
design/fbc_dot.sv
design/frustum_box_cull.sv
tb/frustum_box_cull_tb.sv
